FILE: src/dmmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmmc_pkg;

  // request codes on req_type
  localparam logic [2:0] REQ_LOOKUP       = 3'd0;
  localparam logic [2:0] REQ_FILL         = 3'd1;
  localparam logic [2:0] REQ_CLR_ALL      = 3'd2;
  localparam logic [2:0] REQ_CLR_ID       = 3'd3;
  localparam logic [2:0] REQ_CLR_CLASS    = 3'd4;
  localparam logic [2:0] REQ_CLR_OWNER_ID = 3'd5;

  // class handle is shifted right by this before hashing
  localparam int CLASS_SHIFT = 3;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // what the back end has to do with an item
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LOOKUP,
    CMD_FILL,
    CMD_SWEEP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  req;
    logic [63:0] cls;
    logic [63:0] id;
    logic [63:0] meth;
    logic [63:0] owner;
  } cmd_t;

  // one cache entry
  typedef struct packed {
    logic [63:0] id;
    logic [63:0] cls;
    logic [63:0] owner;
    logic [63:0] meth;
  } entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_status_t;

  typedef struct packed {
    logic clearing;
    logic sweeping;
  } back_status_t;

endpackage

`default_nettype wire

FILE: src/dmmc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dmmc_front #(
  parameter int ENTRIES = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic                       running,
  input  wire logic [2:0]                 req_type,
  input  wire logic [63:0]                class_ref,
  input  wire logic [63:0]                method_id,
  input  wire logic [63:0]                fill_method,
  input  wire logic [63:0]                fill_owner,
  output logic                            push,
  output dmmc_pkg::cmd_t                  push_cmd,
  output logic [$clog2(ENTRIES)-1:0]      push_idx
);
  import dmmc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  logic [63:0]      key;
  logic [IDX_W-1:0] idx_next;
  cmd_t             cmd_next;
  logic             valid;
  cmd_t             cmd;
  logic [IDX_W-1:0] idx;

  // slot index: (class >> 3) xor id, masked to the table
  assign key      = (class_ref >> CLASS_SHIFT) ^ method_id;
  assign idx_next = key[IDX_W-1:0] & IDX_W'(ENTRIES - 1);

  // classify the request; disabled operations turn into a plain zero result
  always_comb begin
    cmd_next.req  = req_type;
    cmd_next.cls  = class_ref;
    cmd_next.id   = method_id;
    cmd_next.meth = fill_method;
    cmd_next.owner = (fill_method == 64'd0) ? 64'd0 : fill_owner;
    case (req_type)
      REQ_LOOKUP: begin
        cmd_next.kind = CMD_LOOKUP;
      end
      REQ_FILL: begin
        cmd_next.kind = ((fill_method == 64'd0) || running) ? CMD_FILL : CMD_NOP;
      end
      REQ_CLR_ALL, REQ_CLR_ID, REQ_CLR_CLASS, REQ_CLR_OWNER_ID: begin
        cmd_next.kind = running ? CMD_SWEEP : CMD_NOP;
      end
      default: begin
        cmd_next.kind = CMD_NOP;
      end
    endcase
  end

  // item register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept;
    end
    if (accept) begin
      cmd <= cmd_next;
      idx <= idx_next;
    end
  end

  assign push     = valid;
  assign push_cmd = cmd;
  assign push_idx = idx;

endmodule

`default_nettype wire

FILE: src/dmmc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dmmc_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output dmmc_pkg::q_status_t   status
);
  import dmmc_pkg::*;

  logic [WIDTH-1:0]  slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign do_pop = pop && (count != '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign pop_data     = slots[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

FILE: src/dmmc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dmmc_back #(
  parameter int ENTRIES = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire dmmc_pkg::cmd_t             q_cmd,
  input  wire logic [$clog2(ENTRIES)-1:0] q_idx,
  output logic                            q_pop,
  output dmmc_pkg::back_status_t          status,
  output logic                            done,
  output logic                            hit,
  output logic [63:0]                     found_method
);
  import dmmc_pkg::*;

  localparam int               IDX_W    = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_SWEEP,
    ST_TAIL
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] cnt;

  // memory and its ports
  entry_t           mem [ENTRIES];
  entry_t           rdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // lookup compare stage
  logic             s2_lookup;
  logic             s2_zero;
  logic [63:0]      s2_cls;
  logic [63:0]      s2_id;
  logic             lk_match;

  // sweep compare and write-back stage
  logic             sw_pend;
  logic [IDX_W-1:0] sw_addr;
  logic [2:0]       sw_req;
  logic [63:0]      sw_cls;
  logic [63:0]      sw_id;
  logic             sw_clr;

  assign lk_match = (rdata.id == s2_id) && (rdata.cls == s2_cls) && (rdata.meth != 64'd0);

  // sweep match on the entry read last cycle
  always_comb begin
    case (sw_req)
      REQ_CLR_ALL:      sw_clr = 1'b1;
      REQ_CLR_ID:       sw_clr = (rdata.id == sw_id);
      REQ_CLR_CLASS:    sw_clr = (rdata.cls == sw_cls) || (rdata.owner == sw_cls);
      REQ_CLR_OWNER_ID: sw_clr = (rdata.owner == sw_cls) && (rdata.id == sw_id);
      default:          sw_clr = 1'b0;
    endcase
  end

  // memory port control
  always_comb begin
    q_pop     = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = q_idx;
    mem_we    = 1'b0;
    mem_waddr = q_idx;
    mem_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
      end
      ST_RUN: begin
        q_pop = q_valid;
        if (q_valid && (q_cmd.kind == CMD_LOOKUP)) begin
          mem_re = 1'b1;
        end
        if (q_valid && (q_cmd.kind == CMD_FILL)) begin
          mem_we    = 1'b1;
          mem_wdata = '{id: q_cmd.id, cls: q_cmd.cls, owner: q_cmd.owner, meth: q_cmd.meth};
        end
      end
      ST_SWEEP: begin
        mem_re    = 1'b1;
        mem_raddr = cnt;
      end
      ST_TAIL: begin
        mem_re = 1'b0;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
    // sweep write-back trails its read by one entry
    if (sw_pend && sw_clr) begin
      mem_we       = 1'b1;
      mem_waddr    = sw_addr;
      mem_wdata    = rdata;
      mem_wdata.id = 64'd0;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      s2_lookup <= 1'b0;
      s2_zero   <= 1'b0;
      sw_pend   <= 1'b0;
      done      <= 1'b0;
      hit       <= 1'b0;
    end else begin
      done         <= s2_lookup || s2_zero || (state == ST_TAIL);
      hit          <= s2_lookup && lk_match;
      found_method <= (s2_lookup && lk_match) ? rdata.meth : 64'd0;
      s2_lookup    <= 1'b0;
      s2_zero      <= 1'b0;
      sw_pend      <= 1'b0;
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            cnt   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (q_valid) begin
            case (q_cmd.kind)
              CMD_LOOKUP: begin
                s2_lookup <= 1'b1;
                s2_cls    <= q_cmd.cls;
                s2_id     <= q_cmd.id;
              end
              CMD_SWEEP: begin
                state  <= ST_SWEEP;
                cnt    <= '0;
                sw_req <= q_cmd.req;
                sw_cls <= q_cmd.cls;
                sw_id  <= q_cmd.id;
              end
              default: begin
                s2_zero <= 1'b1;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          sw_pend <= 1'b1;
          sw_addr <= cnt;
          cnt     <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  assign status.clearing = (state == ST_CLEAR);
  assign status.sweeping = (state == ST_SWEEP) || (state == ST_TAIL);

endmodule

`default_nettype wire

FILE: src/direct_mapped_method_cache_top.sv
// Direct-mapped method cache. After reset the block runs a clearing pass
// over all entries with busy high, then takes one item per cycle while busy
// is low. Lookups and fills stream at one item per cycle while no sweep
// holds the back end; each result appears with done high for one cycle, in
// item order. An invalidation sweep walks the entry memory one entry per
// cycle through its single read and write port and holds the back end until
// its last write-back; items accepted meanwhile wait in a four-deep queue
// and busy rises once three items are queued or on their way into the queue.
// The receiver cannot stall: done is a one-cycle strobe with hit and
// found_method beside it. Write running only while no item is outstanding.
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_method_cache_top #(
  parameter int ENTRIES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [63:0] class_ref,
  input  wire logic [63:0] method_id,
  input  wire logic [63:0] fill_method,
  input  wire logic [63:0] fill_owner,
  output logic             done,
  output logic             hit,
  output logic [63:0]      found_method,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import dmmc_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CMD_W  = $bits(cmd_t);
  localparam int SLOT_W = CMD_W + IDX_W;

  logic             running;
  logic             accept;
  logic             push;
  cmd_t             push_cmd;
  logic [IDX_W-1:0] push_idx;
  logic [SLOT_W-1:0] q_out;
  cmd_t             q_cmd;
  logic [IDX_W-1:0] q_idx;
  logic             q_pop;
  q_status_t        q_stat;
  back_status_t     b_stat;
  logic [QCNT_W:0]  q_load;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      running <= cfg_data;
    end
  end

  // hold off while clearing or when the queue could overflow
  assign q_load = {1'b0, q_stat.count} + (QCNT_W + 1)'(push);
  assign busy   = b_stat.clearing || (q_load >= (QCNT_W + 1)'(QDEPTH - 1));
  assign accept = start && !busy;

  dmmc_front #(
    .ENTRIES(ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .running    (running),
    .req_type   (req_type),
    .class_ref  (class_ref),
    .method_id  (method_id),
    .fill_method(fill_method),
    .fill_owner (fill_owner),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_idx   (push_idx)
  );

  dmmc_queue #(
    .WIDTH(SLOT_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_idx, push_cmd}),
    .pop      (q_pop),
    .pop_data (q_out),
    .status   (q_stat)
  );

  assign q_cmd = q_out[CMD_W-1:0];
  assign q_idx = q_out[SLOT_W-1:CMD_W];

  dmmc_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (!q_stat.empty),
    .q_cmd       (q_cmd),
    .q_idx       (q_idx),
    .q_pop       (q_pop),
    .status      (b_stat),
    .done        (done),
    .hit         (hit),
    .found_method(found_method)
  );

  // no result while the memory is being cleared
  a_no_done_clearing: assert property (@(posedge clk) disable iff (rst)
    b_stat.clearing |-> !done)
    else $error("result during clearing pass");

  // a hit always carries a nonzero handle
  a_hit_handle: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (found_method != 64'd0))
    else $error("hit with zero handle");

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("command queue overflow");

  // nothing leaves the queue while a sweep owns the memory
  a_no_pop_sweep: assert property (@(posedge clk) disable iff (rst)
    b_stat.sweeping |-> !q_pop)
    else $error("queue popped during sweep");

endmodule

`default_nettype wire
